[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle or overlapping implication check, disabled during reset.
`define HSV_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that holds in the cycle after a trigger, disabled during reset.
`define HSV_ASSERT_NEXT(label, clk, rst, trig, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (prop)) \
      else $error(msg);

`endif

[design/hsvrgb_pkg.sv]
// ----------------------------------------------------------------------------
// hsvrgb_pkg
// Types and constants shared by the HSV to RGB pixel converter.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

   // Hue in 1/64 degree: a full turn and one sixth of a turn.
   localparam logic [14:0] HUE_FULL_TURN = 15'd23040;
   localparam int          HUE_SECTOR    = 3840;

   // floor(2^20 / 15), used to divide rem * 256 by 15.
   localparam logic [16:0] RECIP_DIV15   = 17'd69905;

   // 1.0 for saturation and brightness inputs.
   localparam logic [8:0]  UNIT_IN       = 9'd256;

   typedef enum logic [2:0] {
      SECT_RED     = 3'd0,
      SECT_YELLOW  = 3'd1,
      SECT_GREEN   = 3'd2,
      SECT_CYAN    = 3'd3,
      SECT_BLUE    = 3'd4,
      SECT_MAGENTA = 3'd5
   } sector_type;

   typedef struct packed {
      logic [14:0] hue_q;
      logic [8:0]  saturation;
      logic [8:0]  bright;
   } req_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [23:0] grb_word;
   } rsp_type;

endpackage

[design/hsvrgb_frac.sv]
// ----------------------------------------------------------------------------
// hsvrgb_frac
// Three-stage hue splitter: sector = hue / 3840, frac = (rem << 16) / 3840.
// ----------------------------------------------------------------------------
module hsvrgb_frac
   import hsvrgb_pkg::*;
(
   input  logic        clock,
   input  logic        en,
   input  logic [14:0] hue_q,
   output sector_type  sector,
   output logic [15:0] frac
);

   // stage A: wrap, sector by compare, remainder
   logic [14:0] hue_w;
   logic [14:0] base;
   sector_type  sect_a_in;
   logic [11:0] rem_a_in;
   sector_type  sect_a_ff;
   logic [11:0] rem_a_ff;

   always_comb begin
      hue_w     = (hue_q >= HUE_FULL_TURN) ? '0 : hue_q;
      sect_a_in = SECT_RED;
      base      = '0;
      for (int k = 1; k < 6; k++) begin
         if (hue_w >= 15'(k * HUE_SECTOR)) begin
            sect_a_in = sector_type'(3'(k));
            base      = 15'(k * HUE_SECTOR);
         end
      end
      rem_a_in = 12'(hue_w - base);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sect_a_ff <= sect_a_in;
         rem_a_ff  <= rem_a_in;
      end
   end

   // stage B: estimate (rem * 256) / 15 by reciprocal, low by at most one
   logic [28:0] prod_b;
   logic [15:0] qe_b_in;
   logic [15:0] qe_b_ff;
   logic [11:0] rem_b_ff;
   sector_type  sect_b_ff;

   always_comb begin
      prod_b  = {5'b0, rem_a_ff} * {12'b0, RECIP_DIV15};
      qe_b_in = prod_b[27:12];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         qe_b_ff   <= qe_b_in;
         rem_b_ff  <= rem_a_ff;
         sect_b_ff <= sect_a_ff;
      end
   end

   // stage C: one compare-and-correct step
   logic [19:0] resid;
   logic [15:0] frac_c_in;
   logic [15:0] frac_c_ff;
   sector_type  sect_c_ff;

   always_comb begin
      resid     = {rem_b_ff, 8'b0} - (({4'b0, qe_b_ff} << 4) - {4'b0, qe_b_ff});
      frac_c_in = (resid >= 20'd15) ? qe_b_ff + 16'd1 : qe_b_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         frac_c_ff <= frac_c_in;
         sect_c_ff <= sect_b_ff;
      end
   end

   assign sector = sect_c_ff;
   assign frac   = frac_c_ff;

endmodule

[design/hsv_to_rgb_grb_pack_core.sv]
// ----------------------------------------------------------------------------
// hsv_to_rgb_grb_pack_core
// Pipelined six-sector HSV to RGB converter with GRB word packing.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one pixel per transfer (hue in 1/64 degree, saturation and
//            brightness as n/256). Hue at or above 360 degrees reads as 0;
//            saturation and brightness above 256 clamp to 256.
//   rsp_*  : red, green, blue and the GRB-packed word for that pixel.
// A pixel passes stages 1 to 6 between its req transfer and rsp_valid.
// Throughput is one pixel per cycle; all six stages share one advance
// enable, so a pixel enters on every cycle the result register is empty or
// being taken.
// When the receiver holds rsp_ready low with a result waiting, the whole
// pipeline freezes in place and req_ready drops; nothing is lost or repeated.
// Bubbles inside the pipeline move up on any cycle that advances.
// Reset clears every stage valid bit and the result valid; data registers
// are not reset. No state carries from one pixel to the next.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hsv_to_rgb_grb_pack_core
   import hsvrgb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // x in Q16 (1.0 = 65536) to an 8-bit channel: (x * 255) >> 16
   function automatic logic [7:0] to_channel(input logic [16:0] x);
      logic [24:0] prod;
      logic [8:0]  c;
      prod = {x, 8'b0} - {8'b0, x};
      c    = prod[24:16];
      return (c > 9'd255) ? 8'd255 : c[7:0];
   endfunction

   // global advance: result register empty or being taken
   logic en;
   logic rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   // stage valid bits
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   // hue path: stages 1..3
   sector_type  sect3;
   logic [15:0] frac3;

   hsvrgb_frac u_frac (
      .clock  (clock),
      .en     (en),
      .hue_q  (req_data.hue_q),
      .sector (sect3),
      .frac   (frac3)
   );

   // stage 1: clamp saturation and brightness
   logic [8:0] sat1_in, bri1_in;
   logic [8:0] sat1_ff, bri1_ff;

   assign sat1_in = (req_data.saturation > UNIT_IN) ? UNIT_IN : req_data.saturation;
   assign bri1_in = (req_data.bright > UNIT_IN) ? UNIT_IN : req_data.bright;

   always_ff @(posedge clock) begin
      if (en) begin
         sat1_ff <= sat1_in;
         bri1_ff <= bri1_in;
      end
   end

   // stage 2: p = bri * (256 - sat), exact form of (v * (1 - s)) >> 16
   logic [17:0] p2_prod;
   logic [16:0] p2_ff;
   logic [8:0]  sat2_ff, bri2_ff;

   assign p2_prod = {9'b0, bri1_ff} * {9'b0, UNIT_IN - sat1_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         p2_ff   <= p2_prod[16:0];
         sat2_ff <= sat1_ff;
         bri2_ff <= bri1_ff;
      end
   end

   // stage 3: align with the hue path
   logic [16:0] p3_ff;
   logic [8:0]  sat3_ff, bri3_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         p3_ff   <= p2_ff;
         sat3_ff <= sat2_ff;
         bri3_ff <= bri2_ff;
      end
   end

   // stage 4: sf = (s * f) >> 16, st = (s * (1 - f)) >> 16
   logic [16:0] one_minus_f;
   logic [25:0] sf_prod, st_prod;
   logic [16:0] sf4_ff, st4_ff, p4_ff;
   logic [8:0]  bri4_ff;
   logic        grey4_ff;
   sector_type  sect4_ff;

   always_comb begin
      one_minus_f = 17'h10000 - {1'b0, frac3};
      sf_prod     = {17'b0, sat3_ff} * {10'b0, frac3};
      st_prod     = {17'b0, sat3_ff} * {9'b0, one_minus_f};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sf4_ff   <= sf_prod[24:8];
         st4_ff   <= st_prod[24:8];
         p4_ff    <= p3_ff;
         bri4_ff  <= bri3_ff;
         grey4_ff <= (sat3_ff == '0);
         sect4_ff <= sect3;
      end
   end

   // stage 5: q = (v * (1 - sf)) >> 16, t = (v * (1 - st)) >> 16
   logic [16:0] one_minus_sf, one_minus_st;
   logic [25:0] q_prod, t_prod;
   logic [16:0] q5_ff, t5_ff, p5_ff;
   logic [8:0]  bri5_ff;
   logic        grey5_ff;
   sector_type  sect5_ff;

   always_comb begin
      one_minus_sf = 17'h10000 - sf4_ff;
      one_minus_st = 17'h10000 - st4_ff;
      q_prod       = {17'b0, bri4_ff} * {9'b0, one_minus_sf};
      t_prod       = {17'b0, bri4_ff} * {9'b0, one_minus_st};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         q5_ff    <= q_prod[24:8];
         t5_ff    <= t_prod[24:8];
         p5_ff    <= p4_ff;
         bri5_ff  <= bri4_ff;
         grey5_ff <= grey4_ff;
         sect5_ff <= sect4_ff;
      end
   end

   // stage 6: sector select, scale to 8 bits, pack
   logic [16:0] v5;
   logic [16:0] rx, gx, bx;
   rsp_type     rsp_in;
   rsp_type     rsp_ff;

   assign v5 = {bri5_ff, 8'b0};

   always_comb begin
      if (grey5_ff) begin
         rx = v5;
         gx = v5;
         bx = v5;
      end else begin
         case (sect5_ff)
            SECT_RED: begin
               rx = v5;    gx = t5_ff; bx = p5_ff;
            end
            SECT_YELLOW: begin
               rx = q5_ff; gx = v5;    bx = p5_ff;
            end
            SECT_GREEN: begin
               rx = p5_ff; gx = v5;    bx = t5_ff;
            end
            SECT_CYAN: begin
               rx = p5_ff; gx = q5_ff; bx = v5;
            end
            SECT_BLUE: begin
               rx = t5_ff; gx = p5_ff; bx = v5;
            end
            default: begin
               rx = v5;    gx = p5_ff; bx = q5_ff;
            end
         endcase
      end
      rsp_in.red      = to_channel(rx);
      rsp_in.green    = to_channel(gx);
      rsp_in.blue     = to_channel(bx);
      rsp_in.grb_word = {rsp_in.green, rsp_in.red, rsp_in.blue};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // grey pixels leave with equal channels
   `HSV_ASSERT_NEXT(a_grey_equal, clock, reset, v5_ff && grey5_ff && en,
      rsp_valid && rsp_data.red == rsp_data.green && rsp_data.green == rsp_data.blue,
      "grey pixel produced unequal channels")

   // packed word agrees with the separate channels
   `HSV_ASSERT(a_grb_pack, clock, reset,
      rsp_valid |-> (rsp_data.grb_word[23:16] == rsp_data.green &&
                     rsp_data.grb_word[15:8] == rsp_data.red &&
                     rsp_data.grb_word[7:0] == rsp_data.blue),
      "GRB word does not match channels")

   // full saturation drives p to zero
   `HSV_ASSERT(a_full_sat_p, clock, reset,
      (v3_ff && sat3_ff == UNIT_IN) |-> (p3_ff == '0),
      "p nonzero at full saturation")

endmodule
